// File: sv/rsat_pkg.sv
// Shared widths, the root-cell transaction type and input sign extension
// for the rectangle separating-axis test. No dependencies.
`default_nettype none

package rsat_pkg;

    // Coordinate width: the low COORD_BITS of each input port are used, sign-extended.
    localparam int COORD_BITS = 16;
    localparam int IN_W       = 16;
    localparam int AXIS_W     = 16;
    localparam int DEPTH_W    = 25;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    localparam int PX_W  = COORD_BITS + 2;   // derived fourth corner
    localparam int AX_W  = COORD_BITS + 1;   // edge normal component
    localparam int PR_W  = PX_W + AX_W;      // one coordinate product
    localparam int DOT_W = PR_W + 1;         // dot product
    localparam int OV_W  = DOT_W + 1;        // interval overlap
    localparam int SQ_W  = 2 * AX_W;
    localparam int LEN_W = 2 * AX_W - 1;     // squared axis length

    localparam int DEPTH_FRAC = 8;
    localparam int UNIT_SHIFT = 15;
    localparam int UQ = UNIT_SHIFT + 1;      // bits of the unit component root
    localparam int DQ = COORD_BITS + 12;     // bits of the depth root
    localparam int QW = (DQ > UQ) ? DQ : UQ;
    localparam int BIT_W = $clog2(QW);

    localparam int OV_HI = OV_W / 2;
    localparam int OV_LO = OV_W - OV_HI;

    localparam int RW_A = 2 * OV_W + 2 * DEPTH_FRAC;
    localparam int RW_B = 2 * DQ + LEN_W;
    localparam int RW_C = SQ_W + 2 * UNIT_SHIFT;
    localparam int RW_AB = (RW_A > RW_B) ? RW_A : RW_B;
    localparam int RW = ((RW_AB > RW_C) ? RW_AB : RW_C) + 2;

    localparam int NAXES = 4;
    localparam int NCORN = 8;

    // One step of floor(sqrt(rem0 / len2)): rem = num^2 - quo^2*len2, acc = quo*len2
    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [RW-1:0]    acc;
        logic [QW-1:0]    quo;
        logic [LEN_W-1:0] len2;
    } t_root;

    function automatic logic signed [COORD_BITS-1:0] sext(input logic [IN_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/rsat_root_cell.sv
// One cell of the restoring root chain: decides one quotient bit of
// floor(num / sqrt(len2)) with shifts and one wide compare. Uses rsat_pkg.
`default_nettype none

module rsat_root_cell
    import rsat_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [BIT_W-1:0] i_bit,
    input  wire t_root            i_d,
    output t_root                 o_d
);

    t_root         r_d;
    t_root         n_d;
    logic [RW-1:0] w_trial;

    // trial (q + 2^b)^2*len2 - q^2*len2 = 2^(b+1)*acc + 2^(2b)*len2
    always_comb begin
        w_trial = (i_d.acc << (i_bit + 1'b1)) + (RW'(i_d.len2) << {i_bit, 1'b0});
        n_d = i_d;
        if (i_d.rem >= w_trial) begin
            n_d.rem = i_d.rem - w_trial;
            n_d.acc = i_d.acc + (RW'(i_d.len2) << i_bit);
            n_d.quo = i_d.quo | (QW'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// File: sv/rect_separating_axis_test_core.sv
// From input transaction to result: 7 front stages, a
// 28-cell depth root chain, select, square, a 16-cell unit-axis chain, output.
// Throughput one transaction per cycle; the whole pipe holds while a result waits.
// Reset (synchronous, active low) clears the stage valid bits only.
`default_nettype none

module rect_separating_axis_test_core
    import rsat_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output      logic                     o_in_ready,
    input  wire logic signed [IN_W-1:0]   i_a_bl_x,
    input  wire logic signed [IN_W-1:0]   i_a_bl_y,
    input  wire logic signed [IN_W-1:0]   i_a_br_x,
    input  wire logic signed [IN_W-1:0]   i_a_br_y,
    input  wire logic signed [IN_W-1:0]   i_a_tl_x,
    input  wire logic signed [IN_W-1:0]   i_a_tl_y,
    input  wire logic signed [IN_W-1:0]   i_b_bl_x,
    input  wire logic signed [IN_W-1:0]   i_b_bl_y,
    input  wire logic signed [IN_W-1:0]   i_b_br_x,
    input  wire logic signed [IN_W-1:0]   i_b_br_y,
    input  wire logic signed [IN_W-1:0]   i_b_tl_x,
    input  wire logic signed [IN_W-1:0]   i_b_tl_y,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    output      logic                     o_hit,
    output      logic                     o_degenerate,
    output      logic signed [AXIS_W-1:0] o_axis_x,
    output      logic signed [AXIS_W-1:0] o_axis_y,
    output      logic [DEPTH_W-1:0]       o_depth
);

    // Stage numbers: 1..7 front end, then DQ root cells, select, square,
    // UQ unit cells, output register.
    localparam int S_CH  = 7;
    localparam int S_SEL = S_CH + DQ + 1;
    localparam int S_USQ = S_SEL + 1;
    localparam int NSTG  = S_USQ + UQ + 1;

    typedef struct packed {
        logic                        degen;
        logic                        sep;
        logic [NAXES-1:0][AX_W-1:0]  ax;
        logic [NAXES-1:0][AX_W-1:0]  ay;
    } t_side;

    typedef struct packed {
        logic               hit;
        logic               degen;
        logic [DEPTH_W-1:0] depth;
        logic               sx;
        logic               sy;
    } t_uside;

    logic w_en;
    logic r_vld [1:NSTG];

    // ------------------------------------------------------------------
    // Global advance: the pipe moves whenever the output slot is free or
    // being taken this cycle.
    // ------------------------------------------------------------------
    assign w_en        = !r_vld[NSTG] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= NSTG; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_in_valid;
            for (int i = 2; i <= NSTG; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Front end: corners, edge normals, projections, intervals, overlaps
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] w_in [12];
    logic signed [PX_W-1:0]       w_px [NCORN];
    logic signed [PX_W-1:0]       w_py [NCORN];
    logic signed [AX_W-1:0]       w_ax [NAXES];
    logic signed [AX_W-1:0]       w_ay [NAXES];

    assign w_in[0]  = sext(i_a_bl_x);
    assign w_in[1]  = sext(i_a_bl_y);
    assign w_in[2]  = sext(i_a_br_x);
    assign w_in[3]  = sext(i_a_br_y);
    assign w_in[4]  = sext(i_a_tl_x);
    assign w_in[5]  = sext(i_a_tl_y);
    assign w_in[6]  = sext(i_b_bl_x);
    assign w_in[7]  = sext(i_b_bl_y);
    assign w_in[8]  = sext(i_b_br_x);
    assign w_in[9]  = sext(i_b_br_y);
    assign w_in[10] = sext(i_b_tl_x);
    assign w_in[11] = sext(i_b_tl_y);

    // Fourth corner is BR + TL - BL; normal of edge (dx,dy) is (dy,-dx)
    always_comb begin
        for (int r = 0; r < 2; r++) begin
            w_px[r*4+0] = PX_W'(w_in[r*6+0]);
            w_py[r*4+0] = PX_W'(w_in[r*6+1]);
            w_px[r*4+1] = PX_W'(w_in[r*6+2]);
            w_py[r*4+1] = PX_W'(w_in[r*6+3]);
            w_px[r*4+2] = PX_W'(w_in[r*6+2]) + PX_W'(w_in[r*6+4]) - PX_W'(w_in[r*6+0]);
            w_py[r*4+2] = PX_W'(w_in[r*6+3]) + PX_W'(w_in[r*6+5]) - PX_W'(w_in[r*6+1]);
            w_px[r*4+3] = PX_W'(w_in[r*6+4]);
            w_py[r*4+3] = PX_W'(w_in[r*6+5]);
            w_ax[r*2+0] = AX_W'(w_in[r*6+3]) - AX_W'(w_in[r*6+1]);
            w_ay[r*2+0] = AX_W'(w_in[r*6+0]) - AX_W'(w_in[r*6+2]);
            w_ax[r*2+1] = AX_W'(w_in[r*6+5]) - AX_W'(w_in[r*6+1]);
            w_ay[r*2+1] = AX_W'(w_in[r*6+0]) - AX_W'(w_in[r*6+4]);
        end
    end

    logic signed [PX_W-1:0]  r_px   [NCORN];
    logic signed [PX_W-1:0]  r_py   [NCORN];
    logic signed [AX_W-1:0]  r_ax   [NAXES];
    logic signed [AX_W-1:0]  r_ay   [NAXES];
    logic signed [PR_W-1:0]  r_prx  [NAXES][NCORN];
    logic signed [PR_W-1:0]  r_pry  [NAXES][NCORN];
    logic [SQ_W-1:0]         r_sqx  [NAXES];
    logic [SQ_W-1:0]         r_sqy  [NAXES];
    logic signed [DOT_W-1:0] r_dot  [NAXES][NCORN];
    logic [LEN_W-1:0]        r_len3 [NAXES];
    logic signed [DOT_W-1:0] r_mn   [NAXES][2];
    logic signed [DOT_W-1:0] r_mx   [NAXES][2];
    logic [LEN_W-1:0]        r_len4 [NAXES];
    logic [OV_W-1:0]         r_ov   [NAXES];
    logic [LEN_W-1:0]        r_len5 [NAXES];
    logic [2*OV_HI-1:0]      r_hh   [NAXES];
    logic [OV_HI+OV_LO-1:0]  r_hl   [NAXES];
    logic [2*OV_LO-1:0]      r_ll   [NAXES];
    logic [LEN_W-1:0]        r_len6 [NAXES];
    t_root                   r_root [NAXES];
    t_side                   r_sb   [2:S_SEL-1];

    logic signed [DOT_W-1:0] w_mn [NAXES][2];
    logic signed [DOT_W-1:0] w_mx [NAXES][2];
    logic                    w_degen;
    logic                    w_sep;
    logic signed [DOT_W-1:0] w_hi_o [NAXES];
    logic signed [DOT_W-1:0] w_lo_o [NAXES];

    always_comb begin
        w_degen = 1'b0;
        for (int k = 0; k < NAXES; k++) begin
            if (r_sqx[k] == '0 && r_sqy[k] == '0) begin
                w_degen = 1'b1;
            end
        end
    end

    // Interval of each rectangle on each axis
    always_comb begin
        for (int k = 0; k < NAXES; k++) begin
            for (int r = 0; r < 2; r++) begin
                w_mn[k][r] = r_dot[k][r*4];
                w_mx[k][r] = r_dot[k][r*4];
                for (int c = 1; c < 4; c++) begin
                    if (r_dot[k][r*4+c] < w_mn[k][r]) begin
                        w_mn[k][r] = r_dot[k][r*4+c];
                    end
                    if (r_dot[k][r*4+c] > w_mx[k][r]) begin
                        w_mx[k][r] = r_dot[k][r*4+c];
                    end
                end
            end
        end
    end

    // Strict gap on any axis separates; overlap = min(max) - max(min)
    always_comb begin
        w_sep = 1'b0;
        for (int k = 0; k < NAXES; k++) begin
            if (r_mn[k][0] > r_mx[k][1] || r_mn[k][1] > r_mx[k][0]) begin
                w_sep = 1'b1;
            end
            w_hi_o[k] = (r_mx[k][0] < r_mx[k][1]) ? r_mx[k][0] : r_mx[k][1];
            w_lo_o[k] = (r_mn[k][0] > r_mn[k][1]) ? r_mn[k][0] : r_mn[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: geometry
            for (int c = 0; c < NCORN; c++) begin
                r_px[c] <= w_px[c];
                r_py[c] <= w_py[c];
            end
            for (int k = 0; k < NAXES; k++) begin
                r_ax[k] <= w_ax[k];
                r_ay[k] <= w_ay[k];
            end
            // stage 2: products and squared components
            for (int k = 0; k < NAXES; k++) begin
                for (int c = 0; c < NCORN; c++) begin
                    r_prx[k][c] <= PR_W'(r_px[c]) * PR_W'(r_ax[k]);
                    r_pry[k][c] <= PR_W'(r_py[c]) * PR_W'(r_ay[k]);
                end
                r_sqx[k] <= SQ_W'(r_ax[k]) * SQ_W'(r_ax[k]);
                r_sqy[k] <= SQ_W'(r_ay[k]) * SQ_W'(r_ay[k]);
                r_sb[2].ax[k] <= r_ax[k];
                r_sb[2].ay[k] <= r_ay[k];
            end
            r_sb[2].degen <= 1'b0;
            r_sb[2].sep   <= 1'b0;
            // stage 3: dot products and squared lengths
            for (int k = 0; k < NAXES; k++) begin
                for (int c = 0; c < NCORN; c++) begin
                    r_dot[k][c] <= DOT_W'(r_prx[k][c]) + DOT_W'(r_pry[k][c]);
                end
                r_len3[k] <= LEN_W'(r_sqx[k]) + LEN_W'(r_sqy[k]);
            end
            r_sb[3].ax    <= r_sb[2].ax;
            r_sb[3].ay    <= r_sb[2].ay;
            r_sb[3].sep   <= r_sb[2].sep;
            r_sb[3].degen <= w_degen;
            // stage 4: intervals
            for (int k = 0; k < NAXES; k++) begin
                for (int r = 0; r < 2; r++) begin
                    r_mn[k][r] <= w_mn[k][r];
                    r_mx[k][r] <= w_mx[k][r];
                end
                r_len4[k] <= r_len3[k];
            end
            r_sb[4] <= r_sb[3];
            // stage 5: overlaps, separation flag
            for (int k = 0; k < NAXES; k++) begin
                r_ov[k]   <= OV_W'(OV_W'(w_hi_o[k]) - OV_W'(w_lo_o[k]));
                r_len5[k] <= r_len4[k];
            end
            r_sb[5].ax    <= r_sb[4].ax;
            r_sb[5].ay    <= r_sb[4].ay;
            r_sb[5].degen <= r_sb[4].degen;
            r_sb[5].sep   <= w_sep;
            // stage 6: partial squares of the overlap
            for (int k = 0; k < NAXES; k++) begin
                r_hh[k] <= (2*OV_HI)'(r_ov[k][OV_W-1:OV_LO]) * (2*OV_HI)'(r_ov[k][OV_W-1:OV_LO]);
                r_hl[k] <= (OV_HI+OV_LO)'(r_ov[k][OV_W-1:OV_LO])
                           * (OV_HI+OV_LO)'(r_ov[k][OV_LO-1:0]);
                r_ll[k] <= (2*OV_LO)'(r_ov[k][OV_LO-1:0]) * (2*OV_LO)'(r_ov[k][OV_LO-1:0]);
                r_len6[k] <= r_len5[k];
            end
            r_sb[6] <= r_sb[5];
            // stage 7: (overlap << DEPTH_FRAC)^2 seeds the root chain
            for (int k = 0; k < NAXES; k++) begin
                r_root[k].rem  <= ((RW'(r_hh[k]) << (2*OV_LO))
                                 + (RW'(r_hl[k]) << (OV_LO + 1))
                                 + RW'(r_ll[k])) << (2*DEPTH_FRAC);
                r_root[k].acc  <= '0;
                r_root[k].quo  <= '0;
                r_root[k].len2 <= r_len6[k];
            end
            r_sb[S_CH] <= r_sb[6];
            // side data travels alongside the root cells
            for (int i = S_CH + 1; i < S_SEL; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Depth chains: one row of cells per axis, MSB first
    // ------------------------------------------------------------------
    t_root w_dch [NAXES][DQ+1];

    for (genvar k = 0; k < NAXES; k++) begin : g_axis
        assign w_dch[k][0] = r_root[k];
        for (genvar j = 0; j < DQ; j++) begin : g_cell
            rsat_root_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_bit (BIT_W'(DQ - 1 - j)),
                .i_d   (w_dch[k][j]),
                .o_d   (w_dch[k][j+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Select the smallest depth, saturated to DEPTH_MAX; the earlier axis wins ties
    // ------------------------------------------------------------------
    logic [DQ-1:0]          w_best;
    logic [1:0]             w_bi;
    logic [DEPTH_W-1:0]     w_sat;
    t_side                  w_last;

    logic                   r_hit;
    logic                   r_degen;
    logic [DEPTH_W-1:0]     r_depth;
    logic signed [AX_W-1:0] r_cx;
    logic signed [AX_W-1:0] r_cy;
    logic [LEN_W-1:0]       r_clen2;

    assign w_last = r_sb[S_SEL-1];

    always_comb begin
        w_best = w_dch[0][DQ].quo[DQ-1:0];
        w_bi   = 2'd0;
        for (int k = 1; k < NAXES; k++) begin
            if (w_dch[k][DQ].quo[DQ-1:0] < w_best) begin
                w_best = w_dch[k][DQ].quo[DQ-1:0];
                w_bi   = 2'(k);
            end
        end
        if (64'(w_best) > 64'(DEPTH_MAX)) begin
            w_sat = DEPTH_MAX;
        end else begin
            w_sat = DEPTH_W'(w_best);
        end
    end

    t_root  r_uroot [2];
    t_uside r_us    [S_USQ:S_USQ+UQ];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit   <= !w_last.degen && !w_last.sep;
            r_degen <= w_last.degen;
            r_depth <= w_sat;
            r_cx    <= $signed(w_last.ax[w_bi]);
            r_cy    <= $signed(w_last.ay[w_bi]);
            r_clen2 <= w_dch[w_bi][DQ].len2;
            // seed the unit chains with (|c| << UNIT_SHIFT)^2
            r_uroot[0].rem  <= RW'(SQ_W'(SQ_W'(r_cx) * SQ_W'(r_cx))) << (2*UNIT_SHIFT);
            r_uroot[1].rem  <= RW'(SQ_W'(SQ_W'(r_cy) * SQ_W'(r_cy))) << (2*UNIT_SHIFT);
            for (int a = 0; a < 2; a++) begin
                r_uroot[a].acc  <= '0;
                r_uroot[a].quo  <= '0;
                r_uroot[a].len2 <= r_clen2;
            end
            r_us[S_USQ].hit   <= r_hit;
            r_us[S_USQ].degen <= r_degen;
            r_us[S_USQ].depth <= r_depth;
            r_us[S_USQ].sx    <= r_cx[AX_W-1];
            r_us[S_USQ].sy    <= r_cy[AX_W-1];
            for (int i = S_USQ + 1; i <= S_USQ + UQ; i++) begin
                r_us[i] <= r_us[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Unit-axis chains: x and y components of the chosen normal
    // ------------------------------------------------------------------
    t_root w_uch [2][UQ+1];

    for (genvar a = 0; a < 2; a++) begin : g_unit
        assign w_uch[a][0] = r_uroot[a];
        for (genvar j = 0; j < UQ; j++) begin : g_cell
            rsat_root_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_bit (BIT_W'(UQ - 1 - j)),
                .i_d   (w_uch[a][j]),
                .o_d   (w_uch[a][j+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output: round half away from zero, zero the fields unless hit
    // ------------------------------------------------------------------
    logic [UQ:0]         w_qx;
    logic [UQ:0]         w_qy;
    logic [AXIS_W-1:0]   w_ux;
    logic [AXIS_W-1:0]   w_uy;
    t_uside              w_fin;

    assign w_fin = r_us[S_USQ+UQ];
    assign w_qx  = ((UQ+1)'(w_uch[0][UQ].quo[UQ-1:0]) + (UQ+1)'(1)) >> 1;
    assign w_qy  = ((UQ+1)'(w_uch[1][UQ].quo[UQ-1:0]) + (UQ+1)'(1)) >> 1;
    assign w_ux  = w_fin.sx ? AXIS_W'(-AXIS_W'(w_qx)) : AXIS_W'(w_qx);
    assign w_uy  = w_fin.sy ? AXIS_W'(-AXIS_W'(w_qy)) : AXIS_W'(w_qy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit        <= w_fin.hit;
            o_degenerate <= w_fin.degen;
            o_axis_x     <= w_fin.hit ? w_ux : '0;
            o_axis_y     <= w_fin.hit ? w_uy : '0;
            o_depth      <= w_fin.hit ? w_fin.depth : '0;
        end
    end

endmodule

`default_nettype wire
